@@ hdl/bounded_ordered_list_engine_unit_assert.svh @@
// Assertion macros shared by the checkers of this block.
// Each macro samples on the rising edge of clk and is disabled while arst_n is low.
`ifndef BOUNDED_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH
`define BOUNDED_ORDERED_LIST_ENGINE_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BOLE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BOLE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hdl/bole_pkg.sv @@
package bole_pkg;

	localparam int CAPACITY_DEFAULT   = 128;
	localparam int WORD_WIDTH_DEFAULT = 32;

	localparam logic [3:0] OP_GET    = 4'd0;
	localparam logic [3:0] OP_SET    = 4'd1;
	localparam logic [3:0] OP_PUSH   = 4'd2;
	localparam logic [3:0] OP_POP    = 4'd3;
	localparam logic [3:0] OP_INSERT = 4'd4;
	localparam logic [3:0] OP_REMOVE = 4'd5;
	localparam logic [3:0] OP_CLEAR  = 4'd6;
	localparam logic [3:0] OP_FRONT  = 4'd7;
	localparam logic [3:0] OP_BACK   = 4'd8;

	typedef struct packed {
		logic [3:0]         operation;
		logic [6:0]         position;
		logic signed [31:0] write_word;
	} req_t;

	typedef struct packed {
		logic               ok;
		logic signed [31:0] read_word;
		logic [7:0]         entry_count;
		logic               is_empty;
		logic               is_full;
	} rsp_t;

	typedef enum logic [2:0] {
		RA_REQ_POS  = 3'd0,
		RA_ZERO     = 3'd1,
		RA_LAST     = 3'd2,
		RA_PTR      = 3'd3,
		RA_PTR_NEXT = 3'd4
	} rd_sel_t;

	typedef enum logic [2:0] {
		WA_REQ_POS  = 3'd0,
		WA_COUNT    = 3'd1,
		WA_POS      = 3'd2,
		WA_PTR      = 3'd3,
		WA_PTR_NEXT = 3'd4
	} wa_sel_t;

	typedef enum logic [1:0] {
		WD_REQ_WORD = 2'd0,
		WD_WORD     = 2'd1,
		WD_RDATA    = 2'd2
	} wd_sel_t;

	typedef enum logic [2:0] {
		PTR_HOLD         = 3'd0,
		PTR_LOAD_LAST    = 3'd1,
		PTR_LOAD_REQ_POS = 3'd2,
		PTR_INC          = 3'd3,
		PTR_DEC          = 3'd4
	} ptr_op_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2,
		CNT_CLR  = 2'd3
	} cnt_op_t;

	typedef struct packed {
		logic    latch;
		logic    ok;
		logic    rd_en;
		rd_sel_t rd_sel;
		logic    wr_en;
		wa_sel_t wa_sel;
		wd_sel_t wd_sel;
		ptr_op_t ptr_op;
		cnt_op_t cnt_op;
		logic    grab;
		logic    res_load;
	} cmd_t;

	typedef struct packed {
		logic pos_lt_count;
		logic empty;
		logic full;
		logic ptr_eq_pos;
		logic ptr_next_lt_count;
		logic out_free;
	} status_t;

endpackage

@@ hdl/bounded_ordered_list_engine_unit.sv @@
// Fixed-capacity ordered list of signed words, one operation per request.
// Requests arrive on req with req_valid; a transfer happens at a rising edge with
// req_valid high and req_stall low. Each request yields exactly one response on rsp.
// One request is worked on at a time; req_stall stays high until its response has
// been written into the output register, which may still be waiting to be taken.
// Get, pop, front and back take one registered read of the entry memory.
// Insert below the count shifts the entries from the last one down to the position
// up by one before writing the new word; remove returns the entry at the position
// and shifts the entries above it down by one. Other requests need no memory read.
// The next request is taken in the cycle after the response is loaded.
// Insert and remove move one entry at a time, a read and then a write, through the
// single read and single write port of the entry memory, which sets their cost.
// Reset clears the count and the response valid flag; the entries are not
// cleared and are only read after being written.
// While rsp_stall is high the response holds, and a finished request waits
// for the output register before the next request is taken.
module bounded_ordered_list_engine_unit #(
	parameter int CAPACITY   = bole_pkg::CAPACITY_DEFAULT,
	parameter int WORD_WIDTH = bole_pkg::WORD_WIDTH_DEFAULT
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_stall,
	input  bole_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output bole_pkg::rsp_t rsp
);

	bole_pkg::cmd_t    cmd;
	bole_pkg::status_t status;

	bole_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req       (req),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	bole_datapath #(
		.CAPACITY   (CAPACITY),
		.WORD_WIDTH (WORD_WIDTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule

@@ hdl/bole_ctrl.sv @@
module bole_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	input  bole_pkg::req_t   req,
	output logic             req_stall,
	input  bole_pkg::status_t status,
	output bole_pkg::cmd_t   cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_READ     = 9'b000000010,
		S_INS_RD   = 9'b000000100,
		S_INS_WR   = 9'b000001000,
		S_INS_PUT  = 9'b000010000,
		S_REM_GRAB = 9'b000100000,
		S_REM_CHK  = 9'b001000000,
		S_REM_WR   = 9'b010000000,
		S_FIN      = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	assign req_stall = (state_q != S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_FIN;
					unique case (req.operation)
						bole_pkg::OP_GET: begin
							cmd.ok = status.pos_lt_count;
							if (status.pos_lt_count) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = bole_pkg::RA_REQ_POS;
								state_d    = S_READ;
							end
						end
						bole_pkg::OP_SET: begin
							cmd.ok     = status.pos_lt_count;
							cmd.wr_en  = status.pos_lt_count;
							cmd.wa_sel = bole_pkg::WA_REQ_POS;
							cmd.wd_sel = bole_pkg::WD_REQ_WORD;
						end
						bole_pkg::OP_PUSH: begin
							cmd.ok     = !status.full;
							cmd.wr_en  = !status.full;
							cmd.wa_sel = bole_pkg::WA_COUNT;
							cmd.wd_sel = bole_pkg::WD_REQ_WORD;
							if (!status.full) begin
								cmd.cnt_op = bole_pkg::CNT_INC;
							end
						end
						bole_pkg::OP_POP: begin
							cmd.ok = !status.empty;
							if (!status.empty) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = bole_pkg::RA_LAST;
								cmd.cnt_op = bole_pkg::CNT_DEC;
								state_d    = S_READ;
							end
						end
						bole_pkg::OP_INSERT: begin
							cmd.ok = !status.full;
							if (!status.full) begin
								if (status.pos_lt_count) begin
									cmd.ptr_op = bole_pkg::PTR_LOAD_LAST;
									state_d    = S_INS_RD;
								end else begin
									cmd.wr_en  = 1'b1;
									cmd.wa_sel = bole_pkg::WA_COUNT;
									cmd.wd_sel = bole_pkg::WD_REQ_WORD;
									cmd.cnt_op = bole_pkg::CNT_INC;
								end
							end
						end
						bole_pkg::OP_REMOVE: begin
							cmd.ok = status.pos_lt_count;
							if (status.pos_lt_count) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = bole_pkg::RA_REQ_POS;
								cmd.ptr_op = bole_pkg::PTR_LOAD_REQ_POS;
								state_d    = S_REM_GRAB;
							end
						end
						bole_pkg::OP_CLEAR: begin
							cmd.ok     = 1'b1;
							cmd.cnt_op = bole_pkg::CNT_CLR;
						end
						bole_pkg::OP_FRONT: begin
							cmd.ok = !status.empty;
							if (!status.empty) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = bole_pkg::RA_ZERO;
								state_d    = S_READ;
							end
						end
						bole_pkg::OP_BACK: begin
							cmd.ok = !status.empty;
							if (!status.empty) begin
								cmd.rd_en  = 1'b1;
								cmd.rd_sel = bole_pkg::RA_LAST;
								state_d    = S_READ;
							end
						end
						default: begin
							cmd.ok = 1'b0;
						end
					endcase
				end
			end
			S_READ: begin
				cmd.grab = 1'b1;
				state_d  = S_FIN;
			end
			S_INS_RD: begin
				cmd.rd_en  = 1'b1;
				cmd.rd_sel = bole_pkg::RA_PTR;
				state_d    = S_INS_WR;
			end
			S_INS_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = bole_pkg::WA_PTR_NEXT;
				cmd.wd_sel = bole_pkg::WD_RDATA;
				if (status.ptr_eq_pos) begin
					state_d = S_INS_PUT;
				end else begin
					cmd.ptr_op = bole_pkg::PTR_DEC;
					state_d    = S_INS_RD;
				end
			end
			S_INS_PUT: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = bole_pkg::WA_POS;
				cmd.wd_sel = bole_pkg::WD_WORD;
				cmd.cnt_op = bole_pkg::CNT_INC;
				state_d    = S_FIN;
			end
			S_REM_GRAB: begin
				cmd.grab = 1'b1;
				state_d  = S_REM_CHK;
			end
			S_REM_CHK: begin
				if (status.ptr_next_lt_count) begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = bole_pkg::RA_PTR_NEXT;
					state_d    = S_REM_WR;
				end else begin
					cmd.cnt_op = bole_pkg::CNT_DEC;
					state_d    = S_FIN;
				end
			end
			S_REM_WR: begin
				cmd.wr_en  = 1'b1;
				cmd.wa_sel = bole_pkg::WA_PTR;
				cmd.wd_sel = bole_pkg::WD_RDATA;
				cmd.ptr_op = bole_pkg::PTR_INC;
				state_d    = S_REM_CHK;
			end
			S_FIN: begin
				if (status.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

@@ hdl/bole_datapath.sv @@
module bole_datapath #(
	parameter int CAPACITY   = bole_pkg::CAPACITY_DEFAULT,
	parameter int WORD_WIDTH = bole_pkg::WORD_WIDTH_DEFAULT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bole_pkg::req_t    req,
	input  bole_pkg::cmd_t    cmd,
	output bole_pkg::status_t status,
	input  logic              rsp_stall,
	output logic              rsp_valid,
	output bole_pkg::rsp_t    rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = (CW > 7) ? CW : 7;

	logic [WORD_WIDTH-1:0] mem [CAPACITY];
	logic [WORD_WIDTH-1:0] rdata_q;
	logic [WORD_WIDTH-1:0] word_q;
	logic [WORD_WIDTH-1:0] req_word;
	logic [WORD_WIDTH-1:0] wdata;
	logic [31:0]           rd_ext;
	logic [AW-1:0]         pos_q, ptr_q, ptr_d;
	logic [AW-1:0]         req_addr, last_addr, count_addr, ptr_next;
	logic [AW-1:0]         raddr, waddr;
	logic [CW-1:0]         count_q, count_d;
	logic [XW-1:0]         req_pos_x, count_x;
	logic                  ok_q;
	logic signed [31:0]    res_word_q;
	logic                  rsp_valid_q;
	bole_pkg::rsp_t        rsp_q;

	assign req_pos_x  = XW'(req.position);
	assign count_x    = XW'(count_q);
	assign req_addr   = req_pos_x[AW-1:0];
	assign last_addr  = AW'(count_q - CW'(1));
	assign count_addr = AW'(count_q);
	assign ptr_next   = ptr_q + AW'(1);
	assign req_word   = WORD_WIDTH'($unsigned(req.write_word));

	for (genvar b = 0; b < 32; b++) begin : g_ext
		if (b < WORD_WIDTH) begin : g_bit
			assign rd_ext[b] = rdata_q[b];
		end else begin : g_sign
			assign rd_ext[b] = rdata_q[WORD_WIDTH-1];
		end
	end

	assign status.pos_lt_count      = (req_pos_x < count_x);
	assign status.empty             = (count_q == '0);
	assign status.full              = (count_q == CW'(CAPACITY));
	assign status.ptr_eq_pos        = (ptr_q == pos_q);
	assign status.ptr_next_lt_count = ((CW'(ptr_q) + CW'(1)) < count_q);
	assign status.out_free          = !rsp_valid_q || !rsp_stall;

	always_comb begin
		unique case (cmd.rd_sel)
			bole_pkg::RA_REQ_POS:  raddr = req_addr;
			bole_pkg::RA_ZERO:     raddr = '0;
			bole_pkg::RA_LAST:     raddr = last_addr;
			bole_pkg::RA_PTR:      raddr = ptr_q;
			bole_pkg::RA_PTR_NEXT: raddr = ptr_next;
			default:               raddr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wa_sel)
			bole_pkg::WA_REQ_POS:  waddr = req_addr;
			bole_pkg::WA_COUNT:    waddr = count_addr;
			bole_pkg::WA_POS:      waddr = pos_q;
			bole_pkg::WA_PTR:      waddr = ptr_q;
			bole_pkg::WA_PTR_NEXT: waddr = ptr_next;
			default:               waddr = '0;
		endcase
	end

	always_comb begin
		unique case (cmd.wd_sel)
			bole_pkg::WD_REQ_WORD: wdata = req_word;
			bole_pkg::WD_WORD:     wdata = word_q;
			bole_pkg::WD_RDATA:    wdata = rdata_q;
			default:               wdata = req_word;
		endcase
	end

	always_comb begin
		unique case (cmd.cnt_op)
			bole_pkg::CNT_HOLD: count_d = count_q;
			bole_pkg::CNT_INC:  count_d = count_q + CW'(1);
			bole_pkg::CNT_DEC:  count_d = count_q - CW'(1);
			bole_pkg::CNT_CLR:  count_d = '0;
			default:            count_d = count_q;
		endcase
	end

	always_comb begin
		unique case (cmd.ptr_op)
			bole_pkg::PTR_HOLD:         ptr_d = ptr_q;
			bole_pkg::PTR_LOAD_LAST:    ptr_d = last_addr;
			bole_pkg::PTR_LOAD_REQ_POS: ptr_d = req_addr;
			bole_pkg::PTR_INC:          ptr_d = ptr_next;
			bole_pkg::PTR_DEC:          ptr_d = ptr_q - AW'(1);
			default:                    ptr_d = ptr_q;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[waddr] <= wdata;
		end
		if (cmd.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		if (cmd.latch) begin
			pos_q      <= req_addr;
			word_q     <= req_word;
			ok_q       <= cmd.ok;
			res_word_q <= '0;
		end else if (cmd.grab) begin
			res_word_q <= rd_ext;
		end
		if (cmd.res_load) begin
			rsp_q.ok          <= ok_q;
			rsp_q.read_word   <= res_word_q;
			rsp_q.entry_count <= 8'(count_q);
			rsp_q.is_empty    <= (count_q == '0);
			rsp_q.is_full     <= (count_q == CW'(CAPACITY));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.res_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

@@ hdl/bole_checker.sv @@
`include "bounded_ordered_list_engine_unit_assert.svh"

module bole_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           req_valid,
	input logic           req_stall,
	input bole_pkg::req_t req,
	input logic           rsp_valid,
	input logic           rsp_stall,
	input bole_pkg::rsp_t rsp
);

	`BOLE_ASSERT_NXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled response changed")
	`BOLE_ASSERT_NXT(a_one_at_a_time, req_valid && !req_stall, req_stall, "request taken while one is in progress")
	`BOLE_ASSERT_IMP(a_fail_zero, rsp_valid && !rsp.ok, rsp.read_word == 32'sd0, "rejected request returned a word")
	`BOLE_ASSERT_IMP(a_full_not_empty, rsp_valid && rsp.is_full, !rsp.is_empty, "list reported full and empty")

endmodule

bind bounded_ordered_list_engine_unit bole_checker u_bole_checker (.*);
